// File: hw/rtl/u8u16_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants of the UTF-8 to UTF-16 core
// Holds the status codes, the queue command layout and the byte bounds
// that the validating front end compares against.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // Result status codes.
    localparam logic [1:0] ST_UNIT     = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_CAPACITY = 2'd3;

    // Input item kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Queue command opcodes.
    localparam logic [1:0] CMD_UNIT = 2'd0;
    localparam logic [1:0] CMD_PAIR = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // Byte bounds for lead and second-byte checks.
    localparam logic [7:0] LEAD_2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_4_MAX   = 8'hF4;
    localparam logic [7:0] LEAD_E0      = 8'hE0;
    localparam logic [7:0] LEAD_ED      = 8'hED;
    localparam logic [7:0] LEAD_F0      = 8'hF0;
    localparam logic [7:0] LEAD_F4      = 8'hF4;
    localparam logic [7:0] E0_SECOND_LO = 8'hA0;
    localparam logic [7:0] ED_SECOND_HI = 8'h9F;
    localparam logic [7:0] F0_SECOND_LO = 8'h90;
    localparam logic [7:0] F4_SECOND_HI = 8'h8F;

    // Surrogate construction.
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [15:0] HIGH_SURR  = 16'hD800;
    localparam logic [15:0] LOW_SURR   = 16'hDC00;
    localparam int          SURR_BITS  = 10;

    // Command carried from the front end to the back end. For a single
    // unit, arg holds the unit in its low 16 bits; for a pair, arg holds
    // the code point minus 0x10000; for an end, arg holds the status.
    typedef struct packed {
        logic [1:0]  op;
        logic [19:0] arg;
    } u8u16_cmd_t;

endpackage : u8u16_pkg
`default_nettype wire

// File: hw/rtl/u8u16_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_front: UTF-8 decoder and validator
// Accepts one item per cycle while the command queue has room, tracks the
// character in progress, checks capacity and encoding rules, and pushes one
// command per item that produces output.
// ----------------------------------------------------------------------------
module u8u16_front (
    input  wire                    clk,
    input  wire                    rst_n,
    // Configuration
    input  wire                    cfg_wr_en,
    input  wire  [15:0]            cfg_wr_data,
    // Input channel
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire                    kind,
    input  wire  [7:0]             data_byte,
    // Command queue
    output logic                   cmd_valid,
    input  wire                    cmd_ready,
    output u8u16_pkg::u8u16_cmd_t  cmd
);
    import u8u16_pkg::*;

    logic [15:0] capacity_reg;
    logic [1:0]  pending_reg,  pending_next;
    logic [7:0]  lead_reg,     lead_next;
    logic [20:0] point_reg,    point_next;
    logic [15:0] units_reg,    units_next;
    logic [1:0]  failure_reg,  failure_next;

    logic        in_fire;
    logic [15:0] limit;
    logic [2:0]  total;
    logic        second;
    logic        cont_bad;
    logic [20:0] point_add;
    logic [20:0] point_sum;
    logic [20:0] supp_point;
    logic [16:0] units_plus2;
    logic [1:0]  pending_dec;

    assign in_ready = cmd_ready;
    assign in_fire  = in_valid & in_ready;

    // Usable units leave one slot for the terminator.
    assign limit = (capacity_reg == 16'd0) ? 16'd0 : capacity_reg - 16'd1;

    // Sequence length from the stored lead byte.
    always_comb
    begin
        if (lead_reg[7:5] == 3'b110)
            total = 3'd2;
        else if (lead_reg[7:4] == 4'b1110)
            total = 3'd3;
        else
            total = 3'd4;
    end

    assign second = ({1'b0, pending_reg} == total - 3'd1);

    // Continuation byte checks, including the restricted second-byte ranges.
    always_comb
    begin
        cont_bad = (data_byte[7:6] != 2'b10);
        if (second)
        begin
            if ((lead_reg == LEAD_E0) && (data_byte < E0_SECOND_LO))
                cont_bad = 1'b1;
            if ((lead_reg == LEAD_ED) && (data_byte > ED_SECOND_HI))
                cont_bad = 1'b1;
            if ((lead_reg == LEAD_F0) && (data_byte < F0_SECOND_LO))
                cont_bad = 1'b1;
            if ((lead_reg == LEAD_F4) && (data_byte > F4_SECOND_HI))
                cont_bad = 1'b1;
        end
    end

    // Place the six payload bits of a continuation byte.
    always_comb
    begin
        case (pending_reg)
            2'd1:    point_add = {15'd0, data_byte[5:0]};
            2'd2:    point_add = {9'd0, data_byte[5:0], 6'd0};
            2'd3:    point_add = {3'd0, data_byte[5:0], 12'd0};
            default: point_add = 21'd0;
        endcase
    end

    assign point_sum   = point_reg + point_add;
    assign supp_point  = point_sum - SUPP_BASE;
    assign units_plus2 = {1'b0, units_reg} + 17'd2;
    assign pending_dec = pending_reg - 2'd1;

    // Next state and command generation.
    always_comb
    begin
        pending_next = pending_reg;
        lead_next    = lead_reg;
        point_next   = point_reg;
        units_next   = units_reg;
        failure_next = failure_reg;
        cmd_valid    = 1'b0;
        cmd.op       = CMD_UNIT;
        cmd.arg      = 20'd0;

        if (in_fire)
        begin
            if (kind == KIND_END)
            begin
                cmd_valid = 1'b1;
                cmd.op    = CMD_END;
                if (failure_reg != ST_UNIT)
                    cmd.arg = {18'd0, failure_reg};
                else if (pending_reg != 2'd0)
                    cmd.arg = {18'd0, ST_INVALID};
                else
                    cmd.arg = {18'd0, ST_OK};
                pending_next = 2'd0;
                lead_next    = 8'd0;
                point_next   = 21'd0;
                units_next   = 16'd0;
                failure_next = ST_UNIT;
            end
            else if (failure_reg != ST_UNIT)
            begin
                // Bytes after a failure are dropped.
            end
            else if (pending_reg == 2'd0)
            begin
                if (units_reg >= limit)
                begin
                    failure_next = ST_CAPACITY;
                end
                else if (data_byte[7] == 1'b0)
                begin
                    units_next = units_reg + 16'd1;
                    cmd_valid  = 1'b1;
                    cmd.op     = CMD_UNIT;
                    cmd.arg    = {12'd0, data_byte};
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    if (data_byte < LEAD_2_MIN)
                        failure_next = ST_INVALID;
                    else
                    begin
                        point_next   = {10'd0, data_byte[4:0], 6'd0};
                        pending_next = 2'd1;
                        lead_next    = data_byte;
                    end
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    point_next   = {5'd0, data_byte[3:0], 12'd0};
                    pending_next = 2'd2;
                    lead_next    = data_byte;
                end
                else if (data_byte[7:3] == 5'b11110)
                begin
                    if (data_byte > LEAD_4_MAX)
                        failure_next = ST_INVALID;
                    else
                    begin
                        point_next   = {data_byte[2:0], 18'd0};
                        pending_next = 2'd3;
                        lead_next    = data_byte;
                    end
                end
                else
                begin
                    failure_next = ST_INVALID;
                end
            end
            else
            begin
                if (cont_bad)
                begin
                    failure_next = ST_INVALID;
                    pending_next = 2'd0;
                end
                else
                begin
                    point_next   = point_sum;
                    pending_next = pending_dec;
                    if (pending_dec == 2'd0)
                    begin
                        if (total == 3'd4)
                        begin
                            if (units_plus2 > {1'b0, limit})
                            begin
                                failure_next = ST_CAPACITY;
                            end
                            else
                            begin
                                units_next = units_plus2[15:0];
                                cmd_valid  = 1'b1;
                                cmd.op     = CMD_PAIR;
                                cmd.arg    = supp_point[19:0];
                            end
                        end
                        else
                        begin
                            units_next = units_reg + 16'd1;
                            cmd_valid  = 1'b1;
                            cmd.op     = CMD_UNIT;
                            cmd.arg    = {4'd0, point_sum[15:0]};
                        end
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 16'hFFFF;
            pending_reg  <= 2'd0;
            lead_reg     <= 8'd0;
            point_reg    <= 21'd0;
            units_reg    <= 16'd0;
            failure_reg  <= ST_UNIT;
        end
        else
        begin
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
            pending_reg <= pending_next;
            lead_reg    <= lead_next;
            point_reg   <= point_next;
            units_reg   <= units_next;
            failure_reg <= failure_next;
        end
    end

endmodule : u8u16_front
`default_nettype wire

// File: hw/rtl/u8u16_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_fifo: command queue between decoder and emitter
// Small register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module u8u16_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push_valid,
    output logic                   push_ready,
    input  u8u16_pkg::u8u16_cmd_t  push_cmd,
    output logic                   pop_valid,
    input  wire                    pop_ready,
    output u8u16_pkg::u8u16_cmd_t  pop_cmd
);
    import u8u16_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_cmd_t        slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule : u8u16_fifo
`default_nettype wire

// File: hw/rtl/u8u16_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_back: result emitter
// Pops commands and drives the registered output channel, splitting a
// supplementary code point into a high and a low surrogate on two items.
// ----------------------------------------------------------------------------
module u8u16_back (
    input  wire                    clk,
    input  wire                    rst_n,
    // Command queue
    input  wire                    cmd_valid,
    output logic                   cmd_ready,
    input  u8u16_pkg::u8u16_cmd_t  cmd,
    // Output channel
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [15:0]            unit_value,
    output logic [1:0]             status,
    output logic                   last
);
    import u8u16_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] unit_reg,      unit_next;
    logic [1:0]  status_reg,    status_next;
    logic        last_reg,      last_next;
    logic        low_due_reg,   low_due_next;
    logic [9:0]  low_bits_reg,  low_bits_next;
    logic        load;

    // The output register can take a new item when empty or being drained.
    assign load      = !out_valid_reg || out_ready;
    assign cmd_ready = load && !low_due_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        unit_next      = unit_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        low_due_next   = low_due_reg;
        low_bits_next  = low_bits_reg;

        if (load)
        begin
            if (low_due_reg)
            begin
                // Second half of a surrogate pair.
                out_valid_next = 1'b1;
                unit_next      = LOW_SURR | {6'd0, low_bits_reg};
                status_next    = ST_UNIT;
                last_next      = 1'b0;
                low_due_next   = 1'b0;
            end
            else if (cmd_valid)
            begin
                out_valid_next = 1'b1;
                unique case (cmd.op)
                    CMD_UNIT:
                    begin
                        unit_next   = cmd.arg[15:0];
                        status_next = ST_UNIT;
                        last_next   = 1'b0;
                    end
                    CMD_PAIR:
                    begin
                        unit_next     = HIGH_SURR | {6'd0, cmd.arg[19:SURR_BITS]};
                        status_next   = ST_UNIT;
                        last_next     = 1'b0;
                        low_due_next  = 1'b1;
                        low_bits_next = cmd.arg[SURR_BITS-1:0];
                    end
                    default:
                    begin
                        unit_next   = 16'd0;
                        status_next = cmd.arg[1:0];
                        last_next   = 1'b1;
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            low_due_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            low_due_reg   <= low_due_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        unit_reg     <= unit_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
        low_bits_reg <= low_bits_next;
    end

    assign out_valid  = out_valid_reg;
    assign unit_value = unit_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule : u8u16_back
`default_nettype wire

// File: hw/rtl/utf8_to_utf16_validating_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_validating_core: validating UTF-8 to UTF-16 transcoder
// Decodes a byte stream, rejects malformed UTF-8, enforces an output
// capacity and reports a final status item per string.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  input    in         in_valid / in_ready    kind, data_byte
//  output   out        out_valid / out_ready  unit_value, status, last
//  config   in         cfg_wr_en              cfg_wr_data (capacity)
//
//  One input item is taken per cycle while the command queue has room.
//  An item that produces output passes through the command queue into the
//  output register; a surrogate pair leaves it as two items, high one first.
//  The queue of QUEUE_DEPTH commands lets the decoder keep taking bytes
//  while the output side is stalled. Reset clears all string state and
//  sets capacity to 65535; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_to_utf16_validating_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         kind,
    input  wire  [7:0]  data_byte,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [15:0] unit_value,
    output logic [1:0]  status,
    output logic        last
);
    import u8u16_pkg::*;

    u8u16_cmd_t front_cmd;
    u8u16_cmd_t back_cmd;
    logic       front_valid;
    logic       front_ready;
    logic       back_valid;
    logic       back_ready;

    // Decoder and validator.
    u8u16_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready),
        .cmd         (front_cmd)
    );

    // Command queue.
    u8u16_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    // Result emitter.
    u8u16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (back_valid),
        .cmd_ready  (back_ready),
        .cmd        (back_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .unit_value (unit_value),
        .status     (status),
        .last       (last)
    );

endmodule : utf8_to_utf16_validating_core
`default_nettype wire
